// File: sv/hst_pkg.sv
// Package for the homography symmetric transfer inlier block.
// Holds widths, register indexes, payload types, the back-end state type and the adjugate table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hst_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int CNT_CAP    = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
    localparam int CNT_W      = 13;
    localparam int COORD_W    = 32;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int N_COEF     = 9;
    localparam int ADJ_STEPS  = 18;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_00_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_02_10 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_11_12 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_20_21 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_22    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coef;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_u;
        logic signed [COORD_W-1:0] ref_v;
        logic signed [COORD_W-1:0] cur_u;
        logic signed [COORD_W-1:0] cur_v;
        logic                      last_point;
    } t_item;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV_START,
        B_DIV_WAIT,
        B_SQUARE,
        B_SUM,
        B_DONE
    } t_bstate;

    // Operand indexes {a, b} of product step j; each cofactor is a*b - c*d.
    function automatic logic [7:0] adj_opnd(input logic [4:0] j);
        logic [7:0] r;
        case (j)
            5'd0:  r = {4'd4, 4'd8};
            5'd1:  r = {4'd5, 4'd7};
            5'd2:  r = {4'd2, 4'd7};
            5'd3:  r = {4'd1, 4'd8};
            5'd4:  r = {4'd1, 4'd5};
            5'd5:  r = {4'd2, 4'd4};
            5'd6:  r = {4'd6, 4'd5};
            5'd7:  r = {4'd3, 4'd8};
            5'd8:  r = {4'd0, 4'd8};
            5'd9:  r = {4'd6, 4'd2};
            5'd10: r = {4'd3, 4'd2};
            5'd11: r = {4'd0, 4'd5};
            5'd12: r = {4'd3, 4'd7};
            5'd13: r = {4'd6, 4'd4};
            5'd14: r = {4'd6, 4'd1};
            5'd15: r = {4'd0, 4'd7};
            5'd16: r = {4'd0, 4'd4};
            5'd17: r = {4'd3, 4'd1};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/homography_symmetric_transfer_inliers.sv
// Each word is projected both ways by multiply-accumulate, then passes through four serial
// divides, each with set-up, a 64-bit quotient, square and sum.
// The back end takes no new word until the last result is written; the single one-bit-per-cycle divider sets the rate.
// Reset (synchronous, active low) loads the identity homography and a threshold of 2.0,
// clears the count and both queues, and then derives the adjugate,
// during which full stays high; every coefficient write repeats that pass.
`default_nettype none
module homography_symmetric_transfer_inliers (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [hst_pkg::COORD_W-1:0]  i_ref_u,
    input  wire logic signed [hst_pkg::COORD_W-1:0]  i_ref_v,
    input  wire logic signed [hst_pkg::COORD_W-1:0]  i_cur_u,
    input  wire logic signed [hst_pkg::COORD_W-1:0]  i_cur_v,
    input  wire logic                                i_last_point,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     o_is_inlier,
    output logic [hst_pkg::CNT_W-1:0]                o_inlier_total,
    output logic                                     o_set_done,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [hst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [hst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hst_pkg::*;

    logic [63:0] r_c0, r_c1, r_c2, r_c3;
    logic [31:0] r_c22, r_thr;
    logic        w_wr, w_coef_wr;
    t_coef       w_h [N_COEF];
    t_coef       w_g [N_COEF];
    t_item       w_in, w_q_item;
    logic        w_q_valid, w_take;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid;
    assign w_coef_wr   = w_wr && (i_cfg_index == REG_COEF_00_01 ||
                                  i_cfg_index == REG_COEF_02_10 ||
                                  i_cfg_index == REG_COEF_11_12 ||
                                  i_cfg_index == REG_COEF_20_21 ||
                                  i_cfg_index == REG_COEF_22);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0  <= 64'h0100000000000000;
            r_c1  <= 64'd0;
            r_c2  <= 64'h0100000000000000;
            r_c3  <= 64'd0;
            r_c22 <= 32'h01000000;
            r_thr <= 32'h00020000;
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_COEF_00_01: r_c0  <= i_cfg_data;
                REG_COEF_02_10: r_c1  <= i_cfg_data;
                REG_COEF_11_12: r_c2  <= i_cfg_data;
                REG_COEF_20_21: r_c3  <= i_cfg_data;
                REG_COEF_22:    r_c22 <= i_cfg_data[31:0];
                REG_THRESHOLD:  r_thr <= i_cfg_data[31:0];
                default:        r_thr <= r_thr;
            endcase
        end
    end

    assign w_h[0] = r_c0[63:32];
    assign w_h[1] = r_c0[31:0];
    assign w_h[2] = r_c1[63:32];
    assign w_h[3] = r_c1[31:0];
    assign w_h[4] = r_c2[63:32];
    assign w_h[5] = r_c2[31:0];
    assign w_h[6] = r_c3[63:32];
    assign w_h[7] = r_c3[31:0];
    assign w_h[8] = r_c22;

    assign w_in = {i_ref_u, i_ref_v, i_cur_u, i_cur_v, i_last_point};

    hst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (w_in),
        .o_full    (full),
        .i_coef_wr (w_coef_wr),
        .i_h       (w_h),
        .o_g       (w_g),
        .o_valid   (w_q_valid),
        .o_item    (w_q_item),
        .i_take    (w_take)
    );

    hst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_item         (w_q_item),
        .o_take         (w_take),
        .i_h            (w_h),
        .i_g            (w_g),
        .i_thr          (r_thr),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_is_inlier    (o_is_inlier),
        .o_inlier_total (o_inlier_total),
        .o_set_done     (o_set_done)
    );

endmodule
`default_nettype wire

// File: sv/hst_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Used by the back end for the projective divides; depends on hst_pkg.
`default_nettype none
module hst_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [63:0]               i_num,
    input  wire logic signed [hst_pkg::ACC_W-1:0] i_den,
    output logic                                  o_done,
    output logic signed [63:0]                    o_quot
);
    import hst_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [5:0]       r_cnt, n_cnt;
    logic [63:0]      r_n, n_n;
    logic [ACC_W-1:0] r_rem, n_rem;
    logic [ACC_W-1:0] r_dm, n_dm;
    logic             r_neg, n_neg;
    logic [ACC_W:0]   w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_rem   = r_rem;
        n_dm    = r_dm;
        n_neg   = r_neg;
        w_trial = {r_rem, r_n[63]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = '0;
            n_n    = i_num[63] ? 64'(-i_num) : 64'(i_num);
            n_dm   = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
            n_neg  = i_num[63] ^ i_den[ACC_W-1];
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dm}) begin
                n_rem = ACC_W'(w_trial - {1'b0, r_dm});
                n_n   = {r_n[62:0], 1'b1};
            end else begin
                n_rem = w_trial[ACC_W-1:0];
                n_n   = {r_n[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_n   <= n_n;
        r_rem <= n_rem;
        r_dm  <= n_dm;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_n) : $signed(r_n);

endmodule
`default_nettype wire

// File: sv/hst_front.sv
// Front end: two-word input queue and the adjugate unit that derives the inverse mapping.
// Feeds hst_back; depends on hst_pkg.
`default_nettype none
module hst_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hst_pkg::t_item  i_item,
    output logic                 o_full,
    input  wire logic            i_coef_wr,
    input  wire hst_pkg::t_coef  i_h [hst_pkg::N_COEF],
    output hst_pkg::t_coef       o_g [hst_pkg::N_COEF],
    output logic                 o_valid,
    output hst_pkg::t_item       o_item,
    input  wire logic            i_take
);
    import hst_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push_ok;

    logic               r_busy;
    logic [4:0]         r_j;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    t_coef              r_g [N_COEF];
    logic [7:0]         w_op;
    logic [4:0]         w_k;
    logic signed [64:0] w_diff;
    logic signed [64:0] w_rnd;
    t_coef              w_sat;

    assign w_push_ok = i_push && !o_full;
    assign o_full    = (r_cnt == 2'd2) || r_busy;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push_ok} - {1'b0, i_take};
        end
        if (w_push_ok) begin
            r_q[r_wp] <= i_item;
        end
    end

    assign w_op   = adj_opnd(r_j);
    assign w_k    = r_j - 5'd1;
    assign w_diff = 65'(r_acc) - 65'(r_prod);
    assign w_rnd  = (w_diff + 65'sd8388608) >>> 24;

    always_comb begin
        if (w_rnd > 65'sd2147483647) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_rnd < -65'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_j    <= 5'd0;
        end else if (i_coef_wr) begin
            r_busy <= 1'b1;
            r_j    <= 5'd0;
        end else if (r_busy) begin
            r_j <= r_j + 5'd1;
            if (r_j == 5'(ADJ_STEPS)) begin
                r_busy <= 1'b0;
            end
        end
        if (r_busy && r_j < 5'(ADJ_STEPS)) begin
            r_prod <= i_h[w_op[7:4]] * i_h[w_op[3:0]];
        end
        if (r_busy && r_j != 5'd0) begin
            if (!w_k[0]) begin
                r_acc <= r_prod;
            end else begin
                r_g[w_k[4:1]] <= w_sat;
            end
        end
    end

    assign o_g = r_g;

endmodule
`default_nettype wire

// File: sv/hst_back.sv
// Back end: projects both points with one shared multiplier, divides serially,
// sums the saturated squared errors, counts inliers and holds the result word.
// Depends on hst_pkg and hst_div.
`default_nettype none
module hst_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire hst_pkg::t_item               i_item,
    output logic                              o_take,
    input  wire hst_pkg::t_coef               i_h [hst_pkg::N_COEF],
    input  wire hst_pkg::t_coef               i_g [hst_pkg::N_COEF],
    input  wire logic [31:0]                  i_thr,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output logic                              o_is_inlier,
    output logic [hst_pkg::CNT_W-1:0]         o_inlier_total,
    output logic                              o_set_done
);
    import hst_pkg::*;

    t_bstate r_state, n_state;

    t_item                     r_item;
    logic [4:0]                r_p;
    logic [1:0]                r_col;
    logic [2:0]                r_ai;
    logic [2:0]                r_pidx;
    logic                      r_pv;
    logic signed [63:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc [6];
    logic [1:0]                r_d;
    logic                      r_bad;
    logic signed [63:0]        r_diff;
    logic [63:0]               r_sq;
    logic [63:0]               r_sum;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovalid;
    logic                      r_oinl;
    logic [CNT_W-1:0]          r_ototal;
    logic                      r_odone;

    t_coef                     w_m [2*N_COEF];
    t_coef                     w_coef;
    t_coef                     w_coord;
    logic                      w_zero;
    logic                      w_div_start;
    logic                      w_out_wr;
    logic signed [63:0]        w_num;
    logic signed [ACC_W-1:0]   w_den;
    logic                      w_div_done;
    logic signed [63:0]        w_quot;
    t_coef                     w_dcoord;
    logic [63:0]               w_abs;
    logic [64:0]               w_sum;
    logic                      w_inl;
    logic [CNT_W-1:0]          w_cnt;
    logic signed [63:0]        w_shp;

    always_comb begin
        for (int i = 0; i < N_COEF; i++) begin
            w_m[i]          = i_h[i];
            w_m[i + N_COEF] = i_g[i];
        end
    end

    assign w_coef = w_m[r_p];

    always_comb begin
        case (r_col)
            2'd0:    w_coord = (r_ai >= 3'd3) ? r_item.cur_u : r_item.ref_u;
            2'd1:    w_coord = (r_ai >= 3'd3) ? r_item.cur_v : r_item.ref_v;
            default: w_coord = 32'sh00010000;
        endcase
    end

    assign w_zero = (r_acc[2] == '0) || (r_acc[5] == '0);

    always_comb begin
        case (r_d)
            2'd0: begin
                w_num    = {r_acc[0], 16'd0};
                w_den    = r_acc[2];
                w_dcoord = r_item.cur_u;
            end
            2'd1: begin
                w_num    = {r_acc[1], 16'd0};
                w_den    = r_acc[2];
                w_dcoord = r_item.cur_v;
            end
            2'd2: begin
                w_num    = {r_acc[3], 16'd0};
                w_den    = r_acc[5];
                w_dcoord = r_item.ref_u;
            end
            default: begin
                w_num    = {r_acc[4], 16'd0};
                w_den    = r_acc[5];
                w_dcoord = r_item.ref_v;
            end
        endcase
    end

    hst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                if (r_p == 5'(2*N_COEF)) begin
                    n_state = B_DIV_START;
                end
            end
            B_DIV_START: begin
                if (r_d == 2'd0 && w_zero) begin
                    n_state = B_DONE;
                end else begin
                    n_state = B_DIV_WAIT;
                end
            end
            B_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = B_SQUARE;
                end
            end
            B_SQUARE: begin
                n_state = B_SUM;
            end
            B_SUM: begin
                if (r_d == 2'd3) begin
                    n_state = B_DONE;
                end else begin
                    n_state = B_DIV_START;
                end
            end
            B_DONE: begin
                if (w_out_wr) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_take      = 1'b0;
        w_div_start = 1'b0;
        w_out_wr    = 1'b0;
        case (r_state)
            B_IDLE:      o_take      = i_valid;
            B_DIV_START: w_div_start = !(r_d == 2'd0 && w_zero);
            B_DONE:      w_out_wr    = !r_ovalid || i_pop;
            default:     o_take      = 1'b0;
        endcase
    end

    assign w_shp = r_prod >>> 20;
    assign w_abs = r_diff[63] ? 64'(-r_diff) : 64'(r_diff);
    assign w_sum = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_inl = !r_bad && (r_sum < {16'd0, i_thr, 16'd0});

    always_comb begin
        w_cnt = r_count;
        if (w_inl && r_count < CNT_W'(CNT_CAP)) begin
            w_cnt = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_wr) begin
                r_count  <= r_item.last_point ? '0 : w_cnt;
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end

        case (r_state)
            B_IDLE: begin
                r_item <= i_item;
                r_p    <= 5'd0;
                r_col  <= 2'd0;
                r_ai   <= 3'd0;
                r_pv   <= 1'b0;
                r_d    <= 2'd0;
                r_bad  <= 1'b0;
                r_sum  <= '0;
                for (int i = 0; i < 6; i++) begin
                    r_acc[i] <= '0;
                end
            end
            B_MUL: begin
                if (r_p != 5'(2*N_COEF)) begin
                    r_prod <= w_coef * w_coord;
                    r_pidx <= r_ai;
                    r_p    <= r_p + 5'd1;
                    if (r_col == 2'd2) begin
                        r_col <= 2'd0;
                        r_ai  <= r_ai + 3'd1;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                r_pv <= 1'b1;
                if (r_pv) begin
                    r_acc[r_pidx] <= r_acc[r_pidx] + w_shp[ACC_W-1:0];
                end
            end
            B_DIV_START: begin
                if (r_d == 2'd0 && w_zero) begin
                    r_bad <= 1'b1;
                end
            end
            B_DIV_WAIT: begin
                if (w_div_done) begin
                    r_diff <= w_quot - 64'(w_dcoord);
                end
            end
            B_SQUARE: begin
                if (w_abs[63:32] != 32'd0) begin
                    r_sq <= '1;
                end else begin
                    r_sq <= w_abs[31:0] * w_abs[31:0];
                end
            end
            B_SUM: begin
                r_sum <= w_sum[64] ? '1 : w_sum[63:0];
                r_d   <= r_d + 2'd1;
            end
            default: begin
                r_d <= r_d;
            end
        endcase

        if (w_out_wr) begin
            r_oinl   <= w_inl;
            r_ototal <= w_cnt;
            r_odone  <= r_item.last_point;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_is_inlier    = r_oinl;
    assign o_inlier_total = r_ototal;
    assign o_set_done     = r_odone;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for homography_symmetric_transfer_inliers.
// Depends on hst_pkg and the block itself; a built-in predictor computes each expected word
// from the register values that were written and compares it with what the block returns.
module tb_top;
    import hst_pkg::*;

    typedef logic signed [127:0] t_wide;
    typedef t_wide t_mat[9];

    typedef struct packed {
        logic             is_inlier;
        logic [CNT_W-1:0] total;
        logic             set_done;
    } t_verdict;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_CYCLES  = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    t_item drv_word = '0;
    logic o_is_inlier, o_set_done, o_cfg_ready;
    logic [CNT_W-1:0] o_inlier_total;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    homography_symmetric_transfer_inliers dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_ref_u(drv_word.ref_u), .i_ref_v(drv_word.ref_v),
        .i_cur_u(drv_word.cur_u), .i_cur_v(drv_word.cur_v),
        .i_last_point(drv_word.last_point),
        .empty(empty), .pop(pop),
        .o_is_inlier(o_is_inlier), .o_inlier_total(o_inlier_total), .o_set_done(o_set_done),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [63:0] mdl_c0, mdl_c1, mdl_c2, mdl_c3;
    logic [31:0] mdl_c22, mdl_thr;
    int unsigned mdl_count;
    t_item pending_q[$];
    t_verdict verdict_q[$];
    int errors = 0;
    int cycles = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic t_wide cofactor(input t_wide a, input t_wide b, input t_wide c,
                                       input t_wide d);
        t_wide r;
        r = (a * b - c * d + 128'sd8388608) >>> 24;
        if (r > 128'sd2147483647) r = 128'sd2147483647;
        if (r < -128'sd2147483648) r = -128'sd2147483648;
        return r;
    endfunction

    function automatic void load_h(output t_mat h);
        h[0] = $signed(mdl_c0[63:32]); h[1] = $signed(mdl_c0[31:0]);
        h[2] = $signed(mdl_c1[63:32]); h[3] = $signed(mdl_c1[31:0]);
        h[4] = $signed(mdl_c2[63:32]); h[5] = $signed(mdl_c2[31:0]);
        h[6] = $signed(mdl_c3[63:32]); h[7] = $signed(mdl_c3[31:0]);
        h[8] = $signed(mdl_c22);
    endfunction

    function automatic logic map_point(input t_mat m, input t_wide u, input t_wide v,
                                       output t_wide ou, output t_wide ov);
        t_wide nx, ny, w;
        nx = ((m[0] * u) >>> 20) + ((m[1] * v) >>> 20) + (m[2] >>> 4);
        ny = ((m[3] * u) >>> 20) + ((m[4] * v) >>> 20) + (m[5] >>> 4);
        w  = ((m[6] * u) >>> 20) + ((m[7] * v) >>> 20) + (m[8] >>> 4);
        ou = 0;
        ov = 0;
        if (w == 0) return 1'b0;
        ou = (nx * 128'sd65536) / w;
        ov = (ny * 128'sd65536) / w;
        return 1'b1;
    endfunction

    function automatic logic [64:0] square_sat(input t_wide d);
        t_wide a;
        a = (d < 0) ? -d : d;
        if (a >= (128'sd1 <<< 32)) return {1'b0, {64{1'b1}}};
        return {1'b0, a[63:0] * a[63:0]};
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [64:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic t_verdict predict_inlier(input t_item w);
        t_mat h, g;
        t_wide ru, rv, cu, cv, fu, fv, bu, bv;
        logic [63:0] s;
        t_verdict r;
        load_h(h);
        g[0] = cofactor(h[4], h[8], h[5], h[7]);
        g[1] = cofactor(h[2], h[7], h[1], h[8]);
        g[2] = cofactor(h[1], h[5], h[2], h[4]);
        g[3] = cofactor(h[6], h[5], h[3], h[8]);
        g[4] = cofactor(h[0], h[8], h[6], h[2]);
        g[5] = cofactor(h[3], h[2], h[0], h[5]);
        g[6] = cofactor(h[3], h[7], h[6], h[4]);
        g[7] = cofactor(h[6], h[1], h[0], h[7]);
        g[8] = cofactor(h[0], h[4], h[3], h[1]);
        ru = w.ref_u; rv = w.ref_v; cu = w.cur_u; cv = w.cur_v;
        r.is_inlier = 1'b0;
        if (map_point(h, ru, rv, fu, fv) && map_point(g, cu, cv, bu, bv)) begin
            s = add_sat(64'd0, square_sat(fu - cu));
            s = add_sat(s, square_sat(fv - cv));
            s = add_sat(s, square_sat(bu - ru));
            s = add_sat(s, square_sat(bv - rv));
            r.is_inlier = s < {16'd0, mdl_thr, 16'd0};
        end
        if (r.is_inlier && mdl_count < CNT_CAP) mdl_count++;
        r.total = mdl_count[CNT_W-1:0];
        r.set_done = w.last_point;
        if (w.last_point) mdl_count = 0;
        return r;
    endfunction

    // Accepted input words, result words and register writes, all seen at the rising edge.
    always @(posedge i_clk) begin
        t_verdict exp_v;
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            mdl_c0 = 64'h0100000000000000; mdl_c1 = '0;
            mdl_c2 = 64'h0100000000000000; mdl_c3 = '0;
            mdl_c22 = 32'h01000000; mdl_thr = 32'h20000; mdl_count = 0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    REG_COEF_00_01: mdl_c0 = cfg_data;
                    REG_COEF_02_10: mdl_c1 = cfg_data;
                    REG_COEF_11_12: mdl_c2 = cfg_data;
                    REG_COEF_20_21: mdl_c3 = cfg_data;
                    REG_COEF_22:    mdl_c22 = cfg_data[31:0];
                    REG_THRESHOLD:  mdl_thr = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (verdict_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_is_inlier !== exp_v.is_inlier)
                        report($sformatf("is_inlier %b, expected %b", o_is_inlier,
                                         exp_v.is_inlier));
                    if (o_inlier_total !== exp_v.total)
                        report($sformatf("inlier_total %0d, expected %0d", o_inlier_total,
                                         exp_v.total));
                    if (o_set_done !== exp_v.set_done)
                        report($sformatf("set_done %b, expected %b", o_set_done,
                                         exp_v.set_done));
                end
            end
            if (push && !full) begin
                verdict_q.push_back(predict_inlier(drv_word));
                void'(pending_q.pop_front());
            end
        end
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            push <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
            push <= 1'b1;
            drv_word <= pending_q[0];
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(1, 2000);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 700);
            end
        end else begin
            push <= 1'b0;
        end
    end

    int pop_mode = 0;
    int mode_left = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            pop <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_req;
        end else begin
            if (mode_left == 0) begin
                pop_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 1500);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic drain;
        while (pending_q.size() != 0 || verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_word(input logic [31:0] ru, input logic [31:0] rv, input logic [31:0] cu,
                            input logic [31:0] cv, input logic last);
        t_item w;
        w.ref_u = ru; w.ref_v = rv; w.cur_u = cu; w.cur_v = cv; w.last_point = last;
        pending_q.push_back(w);
    endtask

    function automatic logic [31:0] near_coef(input logic [31:0] base, input int spread);
        return base + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Writes a homography close to identity so that consistent point pairs pass the test.
    task automatic write_near_identity(input int spread);
        write_reg(REG_COEF_00_01, {near_coef(32'h01000000, spread), near_coef(0, spread)});
        write_reg(REG_COEF_02_10, {near_coef(0, spread * 256), near_coef(0, spread)});
        write_reg(REG_COEF_11_12, {near_coef(32'h01000000, spread), near_coef(0, spread * 256)});
        write_reg(REG_COEF_20_21, {near_coef(0, spread / 64), near_coef(0, spread / 64)});
        write_reg(REG_COEF_22, {32'd0, near_coef(32'h01000000, spread)});
    endtask

    task automatic add_random_words(input int n);
        t_mat h;
        t_wide ru, rv, fu, fv;
        int set_left;
        int k;
        logic [31:0] cu, cv;
        set_left = $urandom_range(1, 40);
        for (k = 0; k < n; k++) begin
            set_left--;
            ru = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            rv = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            load_h(h);
            if ($urandom_range(0, 4) != 0 && map_point(h, ru, rv, fu, fv)
                && fu < 128'sh40000000 && fu > -128'sh40000000
                && fv < 128'sh40000000 && fv > -128'sh40000000) begin
                cu = fu[31:0] + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
                cv = fv[31:0] + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
                add_word(ru[31:0], rv[31:0], cu, cv, set_left == 0);
            end else begin
                add_word($urandom, $urandom, $urandom, $urandom, set_left == 0);
            end
            if (set_left == 0) set_left = $urandom_range(1, 40);
        end
        add_word(0, 0, 0, 0, 1'b1);
    endtask

    initial begin
        int p;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_word(0, 0, 0, 0, 1'b0);
        add_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        add_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        add_word(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        add_word(32'h00010000, 32'h00010000, 32'h00010000 + 32'h16A09, 32'h00010000, 1'b1);
        add_word(32'h00010000, 32'h00010000, 32'h00010000 + 32'hB504, 32'h00010000, 1'b0);
        add_word(32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 1'b1);
        drain();

        // Zero projective divisor in the forward direction.
        write_reg(REG_COEF_20_21, 64'd0);
        write_reg(REG_COEF_22, 64'd0);
        add_word(0, 0, 0, 0, 1'b0);
        add_word(32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0, 1'b1);
        drain();

        // Extreme coefficients with the widest threshold, then identity with the narrowest threshold.
        write_reg(REG_COEF_00_01, 64'h8000000080000000);
        write_reg(REG_COEF_02_10, 64'h7FFFFFFF7FFFFFFF);
        write_reg(REG_COEF_11_12, 64'h800000007FFFFFFF);
        write_reg(REG_COEF_20_21, 64'h7FFFFFFF80000000);
        write_reg(REG_COEF_22, 64'hFFFFFFFF80000000);
        write_reg(REG_THRESHOLD, 64'hFFFFFFFFFFFFFFFF);
        write_reg(3'd6, 64'h0123456789ABCDEF);
        write_reg(3'd7, 64'hFFFFFFFFFFFFFFFF);
        add_word(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        add_word(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF, 1'b0);
        add_word(32'h00010000, 32'hFFFF0000, 32'h00000000, 32'h00010000, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, 64'd0);
        write_near_identity(0);
        add_word(0, 0, 0, 0, 1'b0);
        add_word(32'h00050000, 32'h00030000, 32'h00050000, 32'h00030000, 1'b1);
        drain();

        for (p = 0; p < 6; p++) begin
            if (p == 5) begin
                write_reg(REG_COEF_00_01, {$urandom, $urandom});
                write_reg(REG_COEF_02_10, {$urandom, $urandom});
                write_reg(REG_COEF_11_12, {$urandom, $urandom});
                write_reg(REG_COEF_20_21, {$urandom, $urandom});
                write_reg(REG_COEF_22, {$urandom, $urandom});
            end else begin
                write_near_identity(p * 4000);
            end
            write_reg(REG_THRESHOLD, (p == 3) ? 64'hFFFFFFFF : {32'd0, $urandom_range(1, 32'h200000)});
            if (p == 2) begin
                hold_req = hold_req + 1;
            end
            add_random_words(220);
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/hst_pkg.sv
sv/hst_div.sv
sv/hst_front.sv
sv/hst_back.sv
sv/homography_symmetric_transfer_inliers.sv
tb/tb_top.sv
